>>> src/izc_pkg.sv
// ----------------------------------------------------------------------------
// izc_pkg
// shared constants and types of the interpolated zero-crossing mean block
// ----------------------------------------------------------------------------
package izc_pkg;

  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned IndexBitsDef  = 12;
  localparam int unsigned FracBitsDef   = 8;
  localparam int unsigned CountBitsDef  = 16;
  localparam int unsigned QueueDepthDef = 4;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_RISING  = 2'd1,
    KIND_FALLING = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_DIV     = 3'd1,
    ST_ACC     = 3'd2,
    ST_MEAN_R  = 3'd3,
    ST_MEAN_F  = 3'd4,
    ST_OUT     = 3'd5,
    ST_LAST    = 3'd6
  } back_state_e;

endpackage

>>> src/interpolated_zero_crossing_mean.sv
// ----------------------------------------------------------------------------
// interpolated_zero_crossing_mean
// mean positions of rising and falling zero crossings along scan lines
// ----------------------------------------------------------------------------
// A front stage pairs every sample with the previous one of its line and
// flags rising or falling crossings; it takes one item per cycle while the
// queue has room. A back stage interpolates each crossing with a bit-serial
// divider, then on a last item (after interpolating it, if it is itself a
// crossing) forms both means with the same divider and presents one result,
// which is held until popped. Items without a crossing are read from the
// queue directly in the idle state, so the sustained rate is one sample per
// cycle as long as crossings are sparse.
module interpolated_zero_crossing_mean #(
  parameter int unsigned SampleBits = izc_pkg::SampleBitsDef,
  parameter int unsigned IndexBits  = izc_pkg::IndexBitsDef,
  parameter int unsigned FracBits   = izc_pkg::FracBitsDef,
  parameter int unsigned CountBits  = izc_pkg::CountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [SampleBits-1:0]         sample_i,
  input  logic [IndexBits-1:0]          sample_index_i,
  input  logic                          line_start_i,
  input  logic                          last_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [IndexBits+FracBits-1:0] rising_mean_o,
  output logic                          rising_valid_o,
  output logic [IndexBits+FracBits-1:0] falling_mean_o,
  output logic                          falling_valid_o,
  output logic [CountBits-1:0]          rising_total_o,
  output logic [CountBits-1:0]          falling_total_o
);
  import izc_pkg::*;

  // queue entry: last, back, kind, num, den, p0, span
  localparam int unsigned EntryBits = 2 + $bits(kind_e) + 2 * (SampleBits + 1)
                                      + 2 * IndexBits;

  logic                  take;
  kind_e                 kind;
  logic [SampleBits:0]   num, den;
  logic [IndexBits-1:0]  p0, span;
  logic                  back;
  logic                  q_full, q_empty, q_rd;
  logic [EntryBits-1:0]  q_rdata;

  assign full = q_full;
  assign take = push && !q_full;

  izc_front #(.SampleBits(SampleBits), .IndexBits(IndexBits)) u_front (
    .clk_i, .rst_ni, .take_i(take), .sample_i, .sample_index_i, .line_start_i,
    .last_i, .kind_o(kind), .num_o(num), .den_o(den), .p0_o(p0),
    .span_o(span), .back_o(back)
  );

  izc_queue #(.Width(EntryBits)) u_queue (
    .clk_i, .rst_ni, .wr_i(take),
    .wdata_i({last_i, back, kind, num, den, p0, span}),
    .full_o(q_full), .rd_i(q_rd), .empty_o(q_empty), .rdata_o(q_rdata)
  );

  izc_back #(
    .SampleBits(SampleBits), .IndexBits(IndexBits), .FracBits(FracBits),
    .CountBits(CountBits), .EntryBits(EntryBits)
  ) u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(q_rdata), .q_rd_o(q_rd),
    .pop, .empty, .rising_mean_o, .rising_valid_o, .falling_mean_o,
    .falling_valid_o, .rising_total_o, .falling_total_o
  );
endmodule

>>> src/izc_divider.sv
// ----------------------------------------------------------------------------
// izc_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module izc_divider #(
  parameter int unsigned NumBits = 40,
  parameter int unsigned DenBits = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quot_q, quot_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, done_q, done_d;
  logic [DenBits:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenBits-1:0], quot_q[NumBits-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

>>> src/izc_front.sv
// ----------------------------------------------------------------------------
// izc_front
// pairs each sample with the previous one and classifies crossings
// ----------------------------------------------------------------------------
module izc_front #(
  parameter int unsigned SampleBits = izc_pkg::SampleBitsDef,
  parameter int unsigned IndexBits  = izc_pkg::IndexBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic [SampleBits-1:0] sample_i,
  input  logic [IndexBits-1:0]  sample_index_i,
  input  logic                  line_start_i,
  input  logic                  last_i,
  output izc_pkg::kind_e        kind_o,
  output logic [SampleBits:0]   num_o,
  output logic [SampleBits:0]   den_o,
  output logic [IndexBits-1:0]  p0_o,
  output logic [IndexBits-1:0]  span_o,
  output logic                  back_o
);
  import izc_pkg::*;

  logic signed [SampleBits-1:0] prev_q;
  logic [IndexBits-1:0]         ppos_q;
  logic                         present_q;
  logic signed [SampleBits-1:0] c1;
  logic signed [SampleBits:0]   c0x, c1x;

  assign c1  = $signed(sample_i);
  assign c0x = {prev_q[SampleBits-1], prev_q};
  assign c1x = {c1[SampleBits-1], c1};

  always_comb begin
    kind_o = KIND_NONE;
    num_o  = '0;
    den_o  = '0;
    if (present_q && !line_start_i) begin
      if (prev_q <= 0 && c1 > 0) begin
        kind_o = KIND_RISING;
        num_o  = -c0x;
        den_o  = c1x - c0x;
      end else if (prev_q >= 0 && c1 < 0) begin
        kind_o = KIND_FALLING;
        num_o  = c0x;
        den_o  = c0x - c1x;
      end
    end
  end

  assign back_o = sample_index_i < ppos_q;
  assign span_o = back_o ? ppos_q - sample_index_i : sample_index_i - ppos_q;
  assign p0_o   = ppos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      ppos_q    <= '0;
      present_q <= 1'b0;
    end else if (take_i) begin
      prev_q    <= c1;
      ppos_q    <= sample_index_i;
      present_q <= !last_i;
    end
  end
endmodule

>>> src/izc_queue.sv
// ----------------------------------------------------------------------------
// izc_queue
// small register fifo between front and back
// ----------------------------------------------------------------------------
module izc_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = izc_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);
  localparam int unsigned PtrBits = $clog2(Depth);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wp_q, rp_q;
  logic [PtrBits:0]   cnt_q;

  assign full_o  = cnt_q == (PtrBits+1)'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= (wp_q == PtrBits'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd_i) rp_q <= (rp_q == PtrBits'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrBits+1)'(wr_i) - (PtrBits+1)'(rd_i);
    end
  end
endmodule

>>> src/izc_back.sv
// ----------------------------------------------------------------------------
// izc_back
// interpolates crossings, accumulates and forms the means
// ----------------------------------------------------------------------------
module izc_back #(
  parameter int unsigned SampleBits = izc_pkg::SampleBitsDef,
  parameter int unsigned IndexBits  = izc_pkg::IndexBitsDef,
  parameter int unsigned FracBits   = izc_pkg::FracBitsDef,
  parameter int unsigned CountBits  = izc_pkg::CountBitsDef,
  parameter int unsigned EntryBits  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  logic [EntryBits-1:0]          q_data_i,
  output logic                          q_rd_o,
  input  logic                          pop,
  output logic                          empty,
  output logic [IndexBits+FracBits-1:0] rising_mean_o,
  output logic                          rising_valid_o,
  output logic [IndexBits+FracBits-1:0] falling_mean_o,
  output logic                          falling_valid_o,
  output logic [CountBits-1:0]          rising_total_o,
  output logic [CountBits-1:0]          falling_total_o
);
  import izc_pkg::*;

  localparam int unsigned PosBits = IndexBits + FracBits;
  localparam int unsigned SumBits = PosBits + CountBits;
  localparam int unsigned OffBits = SampleBits + 1 + IndexBits + FracBits;
  localparam int unsigned NBits   = (OffBits > SumBits + 1) ? OffBits : SumBits + 1;
  localparam int unsigned DBits   = (SampleBits + 1 > CountBits) ? SampleBits + 1 : CountBits;

  // queue entry fields
  logic                  e_last, e_back;
  kind_e                 e_kind;
  logic [SampleBits:0]   e_num, e_den;
  logic [IndexBits-1:0]  e_p0, e_span;
  assign {e_last, e_back, e_kind, e_num, e_den, e_p0, e_span} = q_data_i;

  back_state_e state_q, state_d;
  logic [SumBits-1:0]   rsum_q, rsum_d, fsum_q, fsum_d;
  logic [CountBits-1:0] rcnt_q, rcnt_d, fcnt_q, fcnt_d;
  logic [PosBits-1:0]   rmean_q, rmean_d, fmean_q, fmean_d;
  logic [CountBits-1:0] rtot_q, rtot_d, ftot_q, ftot_d;
  logic                 out_q, out_d;
  logic [NBits-1:0]     mul_q, mul_d;

  logic                 div_start;
  logic [NBits-1:0]     div_num;
  logic [DBits-1:0]     div_den;
  logic                 div_done;
  logic [NBits-1:0]     div_quot;

  izc_divider #(.NumBits(NBits), .DenBits(DBits)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quot_o(div_quot)
  );

  logic [SumBits-1:0]   base, pos, acc;
  logic [SumBits:0]     accw;
  logic [CountBits-1:0] cmax;
  logic                 rkind;

  assign cmax  = '1;
  assign rkind = e_kind == KIND_RISING;
  assign base  = SumBits'({e_p0, {FracBits{1'b0}}});
  assign pos   = e_back ? base - SumBits'(div_quot) : base + SumBits'(div_quot);

  always_comb begin
    state_d   = state_q;
    rsum_d    = rsum_q;
    fsum_d    = fsum_q;
    rcnt_d    = rcnt_q;
    fcnt_d    = fcnt_q;
    rmean_d   = rmean_q;
    fmean_d   = fmean_q;
    rtot_d    = rtot_q;
    ftot_d    = ftot_q;
    out_d     = out_q;
    mul_d     = mul_q;
    q_rd_o    = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    acc       = rkind ? rsum_q : fsum_q;
    accw      = {1'b0, acc} + {1'b0, pos};
    if (out_q && pop) out_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (e_kind != KIND_NONE &&
              (rkind ? rcnt_q != cmax : fcnt_q != cmax)) begin
            // offset numerator, rounded by half the divisor
            mul_d   = NBits'(e_num) * NBits'(e_span);
            state_d = ST_DIV;
          end else if (e_last) begin
            if (!out_q || pop) state_d = ST_MEAN_R;
          end else begin
            q_rd_o = 1'b1;
          end
        end
      end
      ST_DIV: begin
        div_start = 1'b1;
        div_num   = (mul_q << FracBits) + NBits'(e_den >> 1);
        div_den   = DBits'(e_den);
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        if (div_done) begin
          if (rkind) begin
            rcnt_d = rcnt_q + 1'b1;
            rsum_d = accw[SumBits] ? '1 : accw[SumBits-1:0];
          end else begin
            fcnt_d = fcnt_q + 1'b1;
            fsum_d = accw[SumBits] ? '1 : accw[SumBits-1:0];
          end
          if (e_last) begin
            state_d = ST_LAST;
          end else begin
            q_rd_o  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_LAST: begin
        // crossing of the last item is counted, wait for a free result slot
        if (!out_q || pop) state_d = ST_MEAN_R;
      end
      ST_MEAN_R: begin
        if (rcnt_q == '0) begin
          rmean_d = '0;
          state_d = ST_MEAN_F;
        end else if (!div_done) begin
          div_start = 1'b1;
          div_num   = NBits'(rsum_q) + NBits'(rcnt_q >> 1);
          div_den   = DBits'(rcnt_q);
          state_d   = ST_OUT;
          mul_d     = '0;
        end
      end
      ST_OUT: begin
        if (div_done) begin
          if (mul_q == '0) begin
            rmean_d = PosBits'(div_quot);
            state_d = ST_MEAN_F;
          end else begin
            fmean_d = PosBits'(div_quot);
            state_d = ST_MEAN_F;
            mul_d   = {NBits{1'b1}};
          end
        end
      end
      ST_MEAN_F: begin
        if (mul_q != {NBits{1'b1}} && fcnt_q != '0) begin
          div_start = 1'b1;
          div_num   = NBits'(fsum_q) + NBits'(fcnt_q >> 1);
          div_den   = DBits'(fcnt_q);
          mul_d     = NBits'(1);
          state_d   = ST_OUT;
        end else begin
          if (fcnt_q == '0) fmean_d = '0;
          rtot_d  = rcnt_q;
          ftot_d  = fcnt_q;
          out_d   = 1'b1;
          rsum_d  = '0;
          fsum_d  = '0;
          rcnt_d  = '0;
          fcnt_d  = '0;
          q_rd_o  = 1'b1;
          mul_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rsum_q  <= '0;
      fsum_q  <= '0;
      rcnt_q  <= '0;
      fcnt_q  <= '0;
      out_q   <= 1'b0;
      mul_q   <= '0;
    end else begin
      state_q <= state_d;
      rsum_q  <= rsum_d;
      fsum_q  <= fsum_d;
      rcnt_q  <= rcnt_d;
      fcnt_q  <= fcnt_d;
      out_q   <= out_d;
      mul_q   <= mul_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rmean_q <= rmean_d;
    fmean_q <= fmean_d;
    rtot_q  <= rtot_d;
    ftot_q  <= ftot_d;
  end

  assign empty           = !out_q;
  assign rising_mean_o   = rmean_q;
  assign falling_mean_o  = fmean_q;
  assign rising_total_o  = rtot_q;
  assign falling_total_o = ftot_q;
  assign rising_valid_o  = rtot_q != '0;
  assign falling_valid_o = ftot_q != '0;
endmodule

>>> src/izc_checker.sv
// ----------------------------------------------------------------------------
// izc_checker
// port-level checks of the zero-crossing mean block
// ----------------------------------------------------------------------------
module izc_checker #(
  parameter int unsigned CountBits = izc_pkg::CountBitsDef
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 empty,
  input logic                 pop,
  input logic                 rising_valid_o,
  input logic                 falling_valid_o,
  input logic [CountBits-1:0] rising_total_o,
  input logic [CountBits-1:0] falling_total_o
);
  a_rvalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (rising_valid_o == (rising_total_o != '0)))
    else $error("rising valid mismatch");
  a_fvalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (falling_valid_o == (falling_total_o != '0)))
    else $error("falling valid mismatch");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(rising_total_o)))
    else $error("result dropped");
endmodule

bind interpolated_zero_crossing_mean izc_checker #(.CountBits(CountBits)) u_chk (
  .clk_i, .rst_ni, .empty, .pop, .rising_valid_o, .falling_valid_o,
  .rising_total_o, .falling_total_o
);
